// ===== src/smds_pkg.sv =====
// ----------------------------------------------------------------------------
// smds_pkg - shared types and constants for the stroke smoother
// Widths, register indices, sequencer states and the 32-bit clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package smds_pkg;

    localparam int POS_W  = 32;    // Q16.16 coordinate
    localparam int INV_W  = 24;    // Q8.16 inverse mass
    localparam int DRAG_W = 17;    // Q1.16 drag; above 1.0 acts as 1.0
    localparam int STEP_W = 5;     // sub-step count register
    localparam int CFG_W  = 24;    // widest register
    localparam int MA_W   = 34;    // multiplier operand A, signed
    localparam int MB_W   = 25;    // multiplier operand B, signed
    localparam int PROD_W = MA_W + MB_W;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_INV_MASS  = 2'd0;
    localparam t_cfg_idx CFG_DRAG      = 2'd1;
    localparam t_cfg_idx CFG_SUB_STEPS = 2'd2;

    localparam logic [INV_W-1:0]  INV_MASS_RST  = 24'd65536;
    localparam logic [DRAG_W-1:0] DRAG_RST      = 17'd0;
    localparam logic [STEP_W-1:0] SUB_STEPS_RST = 5'd16;

    localparam logic [DRAG_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic signed [31:0] Q16_HALF = 32'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_A,
        ST_MUL_A,
        ST_SAT_A,
        ST_LD_V,
        ST_MUL_V,
        ST_SAT_V,
        ST_LD_N,
        ST_MUL_N,
        ST_NUM,
        ST_DVD,
        ST_DIV,
        ST_ACC,
        ST_VEL,
        ST_POS,
        ST_EMIT
    } t_state;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/stroke_mass_drag_smoother.sv =====
// ----------------------------------------------------------------------------
// stroke_mass_drag_smoother - mass and drag smoothing of a 2D pen stroke
// Pulls a pen model of given inverse mass towards each target point, damps
// its velocity, and emits N sub-step points per target.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------
//  s (in)    input      i_s_tvalid / o_s_tready   tdata: point_x, point_y
//  m (out)   output     o_m_tvalid / i_m_tready   tdata: smooth_x, smooth_y;
//                                                 tlast: last_point
//  cfg       input      i_cfg_wr_en               i_cfg_idx, i_cfg_wdata
//
//  Sequence: the first point, or any point while sub_steps is zero, only
//  loads the position and gives no result. Otherwise each axis steps through
//  LD_A, MUL_A, SAT_A, LD_V, MUL_V, SAT_V, LD_N, MUL_N, NUM and DVD on the
//  shared multiplier and then waits on the restoring divider; each of the N
//  sub-steps then takes six passes through the shared saturating adder plus
//  an emit step.
//  Reset is synchronous and active low; the block is ready straight after.
//  A stalled output holds the sequencer in its emit step until the output
//  register frees up; input is taken only when the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_mass_drag_smoother #(
    parameter int MAX_STEPS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input stream
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [63:0]                i_s_tdata,    // [31:0] point_x, [63:32] point_y
    // output stream
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [63:0]                     o_m_tdata,    // [31:0] smooth_x, [63:32] smooth_y
    output logic                            o_m_tlast,    // last_point
    // configuration
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [smds_pkg::CFG_W-1:0] i_cfg_wdata
);

    // Derived widths: step count, N(N+1)/2, division numerator and its result
    localparam int N_W     = $clog2(MAX_STEPS + 1);
    localparam int PP_W    = 2 * N_W + 1;
    localparam int SUM_MAX = MAX_STEPS * (MAX_STEPS + 1) / 2;
    localparam int S_W     = $clog2(SUM_MAX + 1);
    localparam int NUM_W   = N_W + 35;
    localparam int DC_W    = NUM_W + 1;
    localparam int RND_W   = smds_pkg::PROD_W + 1;
    localparam int MA_W    = smds_pkg::MA_W;
    localparam int MB_W    = smds_pkg::MB_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    smds_pkg::t_state                   r_state, n_state;
    logic                               r_axis, n_axis;
    logic [N_W-1:0]                     r_idx, n_idx;
    logic                               r_started, n_started;
    logic                               r_out_valid, n_out_valid;

    logic signed [31:0]                 r_pos [2];
    logic signed [31:0]                 n_pos [2];
    logic signed [31:0]                 r_vel [2];
    logic signed [31:0]                 n_vel [2];
    logic signed [31:0]                 r_acc [2];
    logic signed [31:0]                 n_acc [2];

    logic [smds_pkg::INV_W-1:0]         r_inv_mass;
    logic [smds_pkg::DRAG_W-1:0]        r_drag;
    logic [smds_pkg::STEP_W-1:0]        r_sub_steps;

    // payload
    logic signed [31:0]                 r_tgt [2];
    logic [N_W-1:0]                     r_n;
    logic [S_W-1:0]                     r_sum;
    logic signed [MA_W-1:0]             r_ma;
    logic signed [MB_W-1:0]             r_mb;
    logic signed [31:0]                 r_a;
    logic signed [31:0]                 r_v;
    logic signed [NUM_W-1:0]            r_num;
    logic signed [DC_W-1:0]             r_dc [2];
    logic signed [31:0]                 r_out_x;
    logic signed [31:0]                 r_out_y;
    logic                               r_out_last;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                               w_in_fire;
    logic                               w_emit;
    logic                               w_last;
    logic [N_W-1:0]                     w_n;
    logic [PP_W-1:0]                    w_nn;
    logic [S_W-1:0]                     w_sum;
    logic [smds_pkg::DRAG_W-1:0]        w_keep;
    logic signed [32:0]                 w_diff;
    logic signed [32:0]                 w_vela;
    logic signed [smds_pkg::PROD_W-1:0] w_prod;
    logic signed [RND_W-1:0]            w_rnd;
    logic signed [RND_W-1:0]            w_shr;
    logic signed [31:0]                 w_scaled;
    logic [S_W-1:0]                     w_half;
    logic [NUM_W-1:0]                   w_dvd;
    logic [NUM_W-1:0]                   w_quo;
    logic                               w_div_done;
    logic                               w_div_start;
    logic signed [31:0]                 w_add_a;
    logic signed [DC_W-1:0]             w_add_b;
    logic signed [31:0]                 w_add_sum;
    logic signed [DC_W-1:0]             w_q_ext;

    // clamp sub_steps to the supported maximum
    always_comb begin
        if (32'(r_sub_steps) > 32'(MAX_STEPS)) begin
            w_n = N_W'(MAX_STEPS);
        end else begin
            w_n = N_W'(r_sub_steps);
        end
    end

    assign w_nn   = PP_W'(w_n) * (PP_W'(w_n) + PP_W'(1));
    assign w_sum  = S_W'(w_nn >> 1);
    assign w_keep = (r_drag > smds_pkg::Q16_ONE) ? '0 : (smds_pkg::Q16_ONE - r_drag);

    assign w_diff = 33'(r_tgt[r_axis]) - 33'(r_pos[r_axis]);
    assign w_vela = 33'(r_vel[r_axis]) + 33'(r_a);

    // round half up on the Q16 scaling, then clamp
    assign w_rnd    = RND_W'(w_prod) + RND_W'(smds_pkg::Q16_HALF);
    assign w_shr    = w_rnd >>> 16;
    assign w_scaled = smds_pkg::f_sat32(64'(w_shr));

    // |num| + sum/2 feeds the divider; sign is restored afterwards
    assign w_half = r_sum >> 1;
    assign w_dvd  = r_num[NUM_W-1] ? (NUM_W'(w_half) - NUM_W'(r_num))
                                   : (NUM_W'(r_num) + NUM_W'(w_half));
    assign w_div_start = (r_state == smds_pkg::ST_DVD);
    assign w_q_ext     = $signed(DC_W'(w_quo));

    // shared adder operands per sub-step phase
    always_comb begin
        case (r_state)
            smds_pkg::ST_VEL: begin
                w_add_a = r_vel[r_axis];
                w_add_b = DC_W'(r_acc[r_axis]);
            end
            smds_pkg::ST_POS: begin
                w_add_a = r_pos[r_axis];
                w_add_b = DC_W'(r_vel[r_axis]);
            end
            default: begin
                w_add_a = r_acc[r_axis];
                w_add_b = r_dc[r_axis];
            end
        endcase
    end

    smds_mul u_mul (
        .i_clk (i_clk),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .o_p   (w_prod)
    );

    smds_div #(
        .DVD_W (NUM_W),
        .DIV_W (S_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (r_sum),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    smds_sadd #(
        .B_W (DC_W)
    ) u_sadd (
        .i_a   (w_add_a),
        .i_b   (w_add_b),
        .o_sum (w_add_sum)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state and architectural updates
    // ------------------------------------------------------------------
    assign o_s_tready = (r_state == smds_pkg::ST_IDLE);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_emit     = (r_state == smds_pkg::ST_EMIT) && (!r_out_valid || i_m_tready);
    assign w_last     = (r_idx == r_n);

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_idx       = r_idx;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_m_tready;
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_acc       = r_acc;

        case (r_state)
            smds_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    if (!r_started || (w_n == '0)) begin
                        // load the target straight into the position
                        n_pos[0]  = $signed(i_s_tdata[31:0]);
                        n_pos[1]  = $signed(i_s_tdata[63:32]);
                        n_started = 1'b1;
                    end else begin
                        n_state = smds_pkg::ST_LD_A;
                        n_axis  = 1'b0;
                        n_idx   = N_W'(1);
                    end
                end
            end
            smds_pkg::ST_LD_A:  n_state = smds_pkg::ST_MUL_A;
            smds_pkg::ST_MUL_A: n_state = smds_pkg::ST_SAT_A;
            smds_pkg::ST_SAT_A: n_state = smds_pkg::ST_LD_V;
            smds_pkg::ST_LD_V:  n_state = smds_pkg::ST_MUL_V;
            smds_pkg::ST_MUL_V: n_state = smds_pkg::ST_SAT_V;
            smds_pkg::ST_SAT_V: n_state = smds_pkg::ST_LD_N;
            smds_pkg::ST_LD_N:  n_state = smds_pkg::ST_MUL_N;
            smds_pkg::ST_MUL_N: n_state = smds_pkg::ST_NUM;
            smds_pkg::ST_NUM:   n_state = smds_pkg::ST_DVD;
            smds_pkg::ST_DVD:   n_state = smds_pkg::ST_DIV;
            smds_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_axis  = !r_axis;
                    n_state = r_axis ? smds_pkg::ST_ACC : smds_pkg::ST_LD_A;
                end
            end
            smds_pkg::ST_ACC: begin
                n_acc[r_axis] = w_add_sum;
                n_state       = smds_pkg::ST_VEL;
            end
            smds_pkg::ST_VEL: begin
                n_vel[r_axis] = w_add_sum;
                n_state       = smds_pkg::ST_POS;
            end
            smds_pkg::ST_POS: begin
                n_pos[r_axis] = w_add_sum;
                n_axis        = !r_axis;
                n_state       = r_axis ? smds_pkg::ST_EMIT : smds_pkg::ST_ACC;
            end
            smds_pkg::ST_EMIT: begin
                // hold until the output register can take the point
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    if (w_last) begin
                        n_state = smds_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = smds_pkg::ST_ACC;
                    end
                end
            end
            default: n_state = smds_pkg::ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smds_pkg::ST_IDLE;
            r_axis      <= 1'b0;
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '{default: '0};
            r_vel       <= '{default: '0};
            r_acc       <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_idx       <= n_idx;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_vel       <= n_vel;
            r_acc       <= n_acc;
        end
    end

    // configuration registers; unknown indices drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass  <= smds_pkg::INV_MASS_RST;
            r_drag      <= smds_pkg::DRAG_RST;
            r_sub_steps <= smds_pkg::SUB_STEPS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                smds_pkg::CFG_INV_MASS:  r_inv_mass  <= i_cfg_wdata;
                smds_pkg::CFG_DRAG:      r_drag      <= i_cfg_wdata[smds_pkg::DRAG_W-1:0];
                smds_pkg::CFG_SUB_STEPS: r_sub_steps <= i_cfg_wdata[smds_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            smds_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    r_tgt[0] <= $signed(i_s_tdata[31:0]);
                    r_tgt[1] <= $signed(i_s_tdata[63:32]);
                    r_n      <= w_n;
                    r_sum    <= w_sum;
                end
            end
            smds_pkg::ST_LD_A: begin
                // offset to target times inverse mass
                r_ma <= MA_W'(w_diff);
                r_mb <= MB_W'(r_inv_mass);
            end
            smds_pkg::ST_SAT_A: r_a <= w_scaled;
            smds_pkg::ST_LD_V: begin
                // (vel + a) times the kept fraction
                r_ma <= MA_W'(w_vela);
                r_mb <= MB_W'(w_keep);
            end
            smds_pkg::ST_SAT_V: r_v <= w_scaled;
            smds_pkg::ST_LD_N: begin
                r_ma <= MA_W'(r_acc[r_axis]);
                r_mb <= MB_W'(r_n);
            end
            smds_pkg::ST_NUM: begin
                r_num <= NUM_W'(r_v) - NUM_W'(r_vel[r_axis])
                       - $signed(w_prod[NUM_W-1:0]);
            end
            smds_pkg::ST_DIV: begin
                if (w_div_done) begin
                    r_dc[r_axis] <= r_num[NUM_W-1] ? -w_q_ext : w_q_ext;
                end
            end
            smds_pkg::ST_EMIT: begin
                if (w_emit) begin
                    r_out_x    <= r_pos[0];
                    r_out_y    <= r_pos[1];
                    r_out_last <= w_last;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_y, r_out_x};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== src/smds_mul.sv =====
// ----------------------------------------------------------------------------
// smds_mul - registered signed multiplier
// One product per cycle, shared by every scaling step of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module smds_mul (
    input  wire logic                                   i_clk,
    input  wire logic signed [smds_pkg::MA_W-1:0]       i_a,
    input  wire logic signed [smds_pkg::MB_W-1:0]       i_b,
    output logic signed [smds_pkg::PROD_W-1:0]          o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= smds_pkg::PROD_W'(i_a) * smds_pkg::PROD_W'(i_b);
    end

endmodule

`default_nettype wire

// ===== src/smds_div.sv =====
// ----------------------------------------------------------------------------
// smds_div - iterative unsigned restoring divider
// One quotient bit per cycle; done pulses once the quotient is settled.
// ----------------------------------------------------------------------------
`default_nettype none

module smds_div #(
    parameter int DVD_W = 40,
    parameter int DIV_W = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [DIV_W-1:0]   i_divisor,
    output logic [DVD_W-1:0]        o_quotient,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   w_shift;
    logic             w_fit;
    logic [DIV_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ===== src/smds_sadd.sv =====
// ----------------------------------------------------------------------------
// smds_sadd - saturating adder
// Adds a wide signed step to a 32-bit value and clamps to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module smds_sadd #(
    parameter int B_W = 41
) (
    input  wire logic signed [31:0]     i_a,
    input  wire logic signed [B_W-1:0]  i_b,
    output logic signed [31:0]          o_sum
);

    localparam int SUM_W = B_W + 1;

    logic signed [SUM_W-1:0] w_sum;

    assign w_sum = SUM_W'(i_a) + SUM_W'(i_b);
    assign o_sum = smds_pkg::f_sat32(64'(w_sum));

endmodule

`default_nettype wire

// ===== tb/sv/stroke_mass_drag_smoother_tb.sv =====
// ----------------------------------------------------------------------------
// stroke_mass_drag_smoother_tb - self-checking bench for the stroke smoother
// Drives pen points over the input stream and register writes over the
// configuration port, keeps its own fixed-point pen model per axis, and
// compares every smoothed point on the output stream with the oldest
// prediction. A directed table comes first, then phases of random settings
// with mostly small pen moves, gaps and back-pressure on both streams but in one phase.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_mass_drag_smoother_tb;

    localparam int                 MAX_STEPS = 16;
    localparam smds_pkg::t_cfg_idx CFG_VOID  = 2'd3;    // beyond the register list
    localparam longint             Q_MAX     = 64'sd2147483647;
    localparam longint             Q_MIN     = -64'sd2147483648;

    // --- block ports, all at known values from time zero -------------------
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_s_tvalid  = 1'b0;
    logic                       o_s_tready;
    logic [63:0]                i_s_tdata   = '0;   // [31:0] point_x, [63:32] point_y
    logic                       o_m_tvalid;
    logic                       i_m_tready  = 1'b0;
    logic [63:0]                o_m_tdata;          // [31:0] smooth_x, [63:32] smooth_y
    logic                       o_m_tlast;          // last_point
    logic                       i_cfg_wr_en = 1'b0;
    smds_pkg::t_cfg_idx         i_cfg_idx   = smds_pkg::CFG_INV_MASS;
    logic [smds_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    stroke_mass_drag_smoother #(
        .MAX_STEPS (MAX_STEPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // --- pen model: settings and per-axis state, at their reset values -----
    logic [smds_pkg::INV_W-1:0]  inv_mass_q = smds_pkg::INV_MASS_RST;
    logic [smds_pkg::DRAG_W-1:0] drag_q     = smds_pkg::DRAG_RST;
    logic [smds_pkg::STEP_W-1:0] steps_q    = smds_pkg::SUB_STEPS_RST;
    logic signed [31:0] pos_x_q = '0, vel_x_q = '0, acc_x_q = '0;
    logic signed [31:0] pos_y_q = '0, vel_y_q = '0, acc_y_q = '0;
    logic               started_q = 1'b0;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last_pt;
    } t_smooth_pt;

    t_smooth_pt smooth_due[$];      // smoothed points still owed by the block
    int         mismatches = 0;
    bit         flow_gaps  = 1'b1;  // clear for a stretch at full rate

    // --- directed plan ------------------------------------------------------
    // ROW_PT   : point checked against the pen model
    // ROW_HOLD : point whose results are obvious: nres copies of the point
    // ROW_CFG  : drain, then write a = inv_mass, b = drag, c = sub_steps
    typedef enum logic [1:0] {ROW_PT, ROW_HOLD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [7:0]  nres;
    } t_plan_row;

    localparam int PLAN_LEN = 26;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // first point after reset only sets the position
        '{ROW_HOLD, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 8'd0},
        // at rest on the same target: all sixteen sub-steps stay put
        '{ROW_HOLD, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 8'd16},
        '{ROW_PT,   32'h0005_0000, 32'h0003_8000, 32'h0, 8'd0},
        '{ROW_PT,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'd0},
        '{ROW_PT,   32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 8'd0},
        '{ROW_PT,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 8'd0},
        // no acceleration, full stop
        '{ROW_CFG,  32'h00_0000,   32'h01_0000,   32'h00_0010, 8'd0},
        '{ROW_PT,   32'h1234_5678, 32'hEDCB_A988, 32'h0, 8'd0},
        '{ROW_PT,   32'h0000_0000, 32'h0000_0000, 32'h0, 8'd0},
        // widest inverse mass, drag above one, too many sub-steps, junk bits
        '{ROW_CFG,  32'hFF_FFFF,   32'hFF_FFFF,   32'hFF_FFFF, 8'd0},
        '{ROW_PT,   32'h8000_0000, 32'h8000_0000, 32'h0, 8'd0},
        '{ROW_PT,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 8'd0},
        // zero sub-steps: position load only, junk above the count
        '{ROW_CFG,  32'h01_0000,   32'h00_8000,   32'hE0_0000, 8'd0},
        '{ROW_HOLD, 32'h0100_0000, 32'h0200_0000, 32'h0, 8'd0},
        '{ROW_HOLD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'd0},
        // a single sub-step
        '{ROW_CFG,  32'h00_4000,   32'h00_0000,   32'h00_0001, 8'd0},
        '{ROW_PT,   32'h7FFF_0000, 32'h8001_0000, 32'h0, 8'd0},
        '{ROW_PT,   32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 8'd0},
        // seventeen requested, sixteen taken
        '{ROW_CFG,  32'h01_0000,   32'h00_0000,   32'h00_0011, 8'd0},
        '{ROW_PT,   32'h0002_0000, 32'hFFFE_0000, 32'h0, 8'd0},
        '{ROW_PT,   32'h0002_4000, 32'hFFFD_C000, 32'h0, 8'd0},
        '{ROW_CFG,  32'h02_0000,   32'h00_C000,   32'h00_0003, 8'd0},
        '{ROW_PT,   32'h0010_0000, 32'h0008_0000, 32'h0, 8'd0},
        '{ROW_PT,   32'hFFF0_0000, 32'h0000_8000, 32'h0, 8'd0},
        '{ROW_PT,   32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 8'd0},
        '{ROW_PT,   32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 8'd0}
    };

    // --- clock ----------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // --- pen model arithmetic ------------------------------------------------
    function automatic logic signed [31:0] clamp32(input longint v);
        logic signed [31:0] r;
        if (v > Q_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < Q_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Acceleration change per sub-step for one axis, kept wide
    function automatic longint accel_change(input logic signed [31:0] target,
                                            input logic signed [31:0] pos,
                                            input logic signed [31:0] vel,
                                            input logic signed [31:0] acc,
                                            input int n);
        longint keep, diff, tri_sum, num, mag, q;
        logic signed [31:0] a, v;
        keep = (drag_q > smds_pkg::Q16_ONE) ? 64'sd0 : 64'sd65536 - longint'(drag_q);
        diff = longint'(target) - longint'(pos);
        // round half up on the 2^16 rescale
        a = clamp32((diff * longint'(inv_mass_q) + 64'sd32768) >>> 16);
        v = clamp32(((longint'(vel) + longint'(a)) * keep + 64'sd32768) >>> 16);
        tri_sum = longint'(n) * longint'(n + 1) / 2;
        num = longint'(v) - longint'(vel) - longint'(n) * longint'(acc);
        // round half away from zero on the divide
        mag = (num < 0) ? -num : num;
        q = (mag + tri_sum / 2) / tri_sum;
        return (num < 0) ? -q : q;
    endfunction

    // Advance the pen model by one target point; queue its points if asked
    task automatic advance_pen(input logic signed [31:0] tx, input logic signed [31:0] ty,
                               input bit queue_pts);
        int n;
        longint dcx, dcy;
        n = (steps_q > MAX_STEPS) ? MAX_STEPS : int'(steps_q);
        if (!started_q || n == 0) begin
            // first point or no sub-steps: load the position, keep the motion
            pos_x_q   = tx;
            pos_y_q   = ty;
            started_q = 1'b1;
        end else begin
            dcx = accel_change(tx, pos_x_q, vel_x_q, acc_x_q, n);
            dcy = accel_change(ty, pos_y_q, vel_y_q, acc_y_q, n);
            for (int i = 0; i < n; i++) begin
                acc_x_q = clamp32(longint'(acc_x_q) + dcx);
                vel_x_q = clamp32(longint'(vel_x_q) + longint'(acc_x_q));
                pos_x_q = clamp32(longint'(pos_x_q) + longint'(vel_x_q));
                acc_y_q = clamp32(longint'(acc_y_q) + dcy);
                vel_y_q = clamp32(longint'(vel_y_q) + longint'(acc_y_q));
                pos_y_q = clamp32(longint'(pos_y_q) + longint'(vel_y_q));
                if (queue_pts) begin
                    smooth_due.push_back(t_smooth_pt'{x: pos_x_q, y: pos_y_q,
                                                      last_pt: (i == n - 1)});
                end
            end
        end
    endtask

    // --- stimulus tasks -------------------------------------------------------
    // Offer one point, with a random gap first, and hold it until taken
    task automatic push_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input bit use_model);
        if (flow_gaps && $urandom_range(99) < 32) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while (flow_gaps && $urandom_range(99) < 32);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_tready);
        advance_pen(px, py, use_model);
    endtask

    // Hold the input until every owed point is out and the block is idle
    task automatic drain_points();
        i_s_tvalid <= 1'b0;
        while (smooth_due.size() != 0) @(posedge i_clk);
        // a point that gives no result may still be in progress
        repeat (16) @(posedge i_clk);
    endtask

    // Write all three registers, then a junk write beyond the list
    task automatic load_settings(input logic [smds_pkg::CFG_W-1:0] inv_w,
                                 input logic [smds_pkg::CFG_W-1:0] drag_w,
                                 input logic [smds_pkg::CFG_W-1:0] steps_w);
        logic [smds_pkg::CFG_W-1:0] word [4];
        smds_pkg::t_cfg_idx         slot [4];
        word = '{inv_w, drag_w, steps_w, smds_pkg::CFG_W'($urandom())};
        slot = '{smds_pkg::CFG_INV_MASS, smds_pkg::CFG_DRAG, smds_pkg::CFG_SUB_STEPS,
                 CFG_VOID};
        for (int k = 0; k < 4; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= slot[k];
            i_cfg_wdata <= word[k];
            @(posedge i_clk);
            case (slot[k])
                smds_pkg::CFG_INV_MASS:  inv_mass_q = word[k][smds_pkg::INV_W-1:0];
                smds_pkg::CFG_DRAG:      drag_q     = word[k][smds_pkg::DRAG_W-1:0];
                smds_pkg::CFG_SUB_STEPS: steps_q    = word[k][smds_pkg::STEP_W-1:0];
                default:                 ;
            endcase
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Pick a random setting, extremes included, often with junk upper bits
    task automatic shuffle_settings();
        logic [smds_pkg::CFG_W-1:0] inv_w, drag_w, steps_w;
        case ($urandom_range(4))
            0:       inv_w = 24'h00_0000;
            1:       inv_w = 24'hFF_FFFF;
            2:       inv_w = smds_pkg::INV_MASS_RST;
            3:       inv_w = 24'($urandom());
            default: inv_w = 24'($urandom_range(24'h02_0000));
        endcase
        case ($urandom_range(4))
            0:       drag_w = {7'($urandom()), 17'h0_0000};
            1:       drag_w = {7'($urandom()), smds_pkg::Q16_ONE};
            2:       drag_w = 24'($urandom());
            default: drag_w = 24'($urandom_range(17'h1_0000));
        endcase
        case ($urandom_range(5))
            0:       steps_w = {19'($urandom()), 5'd0};
            1:       steps_w = 24'd16;
            2:       steps_w = 24'($urandom());
            default: steps_w = 24'($urandom_range(4, 1));
        endcase
        load_settings(inv_w, drag_w, steps_w);
    endtask

    // Mostly a small move from where the pen is, sometimes anywhere or an edge
    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] near);
        logic signed [31:0] c;
        case ($urandom_range(9))
            0: c = $urandom();
            1: begin
                case ($urandom_range(3))
                    0:       c = 32'sh8000_0000;
                    1:       c = 32'sh7FFF_FFFF;
                    2:       c = 32'sh0000_0000;
                    default: c = -32'sd1;
                endcase
            end
            default: c = clamp32(longint'(near) + longint'($urandom_range(2097152))
                                 - 64'sd1048576);
        endcase
        return c;
    endfunction

    // --- output sink: random back-pressure ------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= !(flow_gaps && $urandom_range(99) < 32);
    end

    // --- output checker: each transaction against the oldest prediction -------
    always @(posedge i_clk) begin
        t_smooth_pt due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (smooth_due.size() == 0) begin
                $display("%0t: unexpected point x %h y %h last %b", $time,
                         o_m_tdata[31:0], o_m_tdata[63:32], o_m_tlast);
                mismatches++;
            end else begin
                due = smooth_due.pop_front();
                if (o_m_tdata[31:0] !== due.x) begin
                    $display("%0t: smooth_x expected %h got %h", $time, due.x,
                             o_m_tdata[31:0]);
                    mismatches++;
                end
                if (o_m_tdata[63:32] !== due.y) begin
                    $display("%0t: smooth_y expected %h got %h", $time, due.y,
                             o_m_tdata[63:32]);
                    mismatches++;
                end
                if (o_m_tlast !== due.last_pt) begin
                    $display("%0t: last_point expected %b got %b", $time, due.last_pt,
                             o_m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // --- main sequence ---------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: obvious rows carry their own results
        for (int r = 0; r < PLAN_LEN; r++) begin
            case (PLAN[r].kind)
                ROW_CFG: begin
                    drain_points();
                    load_settings(PLAN[r].a[smds_pkg::CFG_W-1:0],
                                  PLAN[r].b[smds_pkg::CFG_W-1:0],
                                  PLAN[r].c[smds_pkg::CFG_W-1:0]);
                end
                ROW_HOLD: begin
                    push_point(PLAN[r].a, PLAN[r].b, 1'b0);
                    for (int j = 0; j < int'(PLAN[r].nres); j++) begin
                        smooth_due.push_back(t_smooth_pt'{x: PLAN[r].a, y: PLAN[r].b,
                                             last_pt: (j == int'(PLAN[r].nres) - 1)});
                    end
                end
                default: push_point(PLAN[r].a, PLAN[r].b, 1'b1);
            endcase
        end

        // random phases: drain, fresh settings, then a run of pen moves;
        // phase two runs both streams flat out
        for (int ph = 0; ph < 6; ph++) begin
            drain_points();
            flow_gaps = (ph != 2);
            shuffle_settings();
            for (int p = 0; p < 22; p++) begin
                push_point(pick_coord(pos_x_q), pick_coord(pos_y_q), 1'b1);
            end
        end
        flow_gaps = 1'b1;

        // drop valid, wait for the last owed point, then watch for strays
        i_s_tvalid <= 1'b0;
        while (smooth_due.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // --- watchdog: generous bound on the whole run -----------------------------
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/smds_pkg.sv
src/smds_mul.sv
src/smds_div.sv
src/smds_sadd.sv
src/stroke_mass_drag_smoother.sv
tb/sv/stroke_mass_drag_smoother_tb.sv
